### hw/rtl/wbpm_pkg.sv
package wbpm_pkg;

  // defaults for the top level parameters
  localparam int unsigned PatternMaxDefault = 16;
  localparam int unsigned OffsetBitsDefault = 32;

  // configured pattern storage is fixed at sixteen positions
  localparam int unsigned CfgPositions = 16;
  // wide enough for any pattern position up to the largest window
  localparam int unsigned PosW = 7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LenCfgW  = 5;
  localparam int unsigned OutOffW  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLow   = 3'd0,
    CfgPatHigh  = 3'd1,
    CfgWildMask = 3'd2,
    CfgPatLen   = 3'd3,
    CfgCaseIns  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic               match_hit;
    logic [OutOffW-1:0] match_offset;
    logic               first_hit;
    logic               file_end;
    logic               file_had_match;
  } out_beat_t;

  // per-cycle control shared by every cell
  typedef struct packed {
    logic shift;
    logic clear;
    logic fold;
  } cell_ctrl_t;

  // pattern position that a cell is lined up against
  typedef struct packed {
    logic [7:0] pat_byte;
    logic       wild;
    logic       active;
  } cell_pat_t;

  // ascii upper case to lower case when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && (b >= 8'h41) && (b <= 8'h5a)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

### hw/rtl/wbpm_if.sv
interface wbpm_in_if;
  logic                valid;
  logic                ready;
  wbpm_pkg::in_beat_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface wbpm_out_if;
  logic                valid;
  logic                ready;
  wbpm_pkg::out_beat_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/wbpm_cell.sv
module wbpm_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wbpm_pkg::cell_ctrl_t ctrl_i,
  input  wbpm_pkg::cell_pat_t  pat_i,
  input  logic [7:0]           byte_i,
  output logic [7:0]           byte_o,
  output logic                 match_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (ctrl_i.shift) begin
      byte_q <= ctrl_i.clear ? 8'h00 : byte_i;
    end
  end

  // compare on the byte entering this slot
  always_comb begin
    match_o = 1'b1;
    if (pat_i.active && !pat_i.wild) begin
      match_o = (wbpm_pkg::fold_byte(byte_i, ctrl_i.fold) ==
                 wbpm_pkg::fold_byte(pat_i.pat_byte, ctrl_i.fold));
    end
  end

  assign byte_o = byte_q;

endmodule

### hw/rtl/wildcard_byte_pattern_matcher.sv
// Wildcard byte pattern matcher: takes one stream byte per beat and returns one result
// beat per byte, at a sustained rate of one byte per clock while the sink takes results;
// each result beat is registered from its input beat. The last bytes of the file sit in
// a row of PATTERN_MAX cells that shift by one on every accepted byte; each cell compares
// its slot against the pattern position lined up with it, so a whole window is checked
// in the cycle the byte arrives and the outcome lands in a single output register.
// A result waiting in that register does not hold up the input unless the sink stalls.
// Configure the pattern through the write port only while no beat is in flight; the
// byte count, window and match flag restart after a beat marked last_byte.
module wildcard_byte_pattern_matcher #(
  parameter int unsigned PATTERN_MAX = wbpm_pkg::PatternMaxDefault,
  parameter int unsigned OFFSET_BITS = wbpm_pkg::OffsetBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wbpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbpm_pkg::CfgDataW-1:0] cfg_data_i,
  wbpm_in_if.sink                       in_i,
  wbpm_out_if.source                    out_o
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  // configuration registers
  logic [63:0]                     pat_low_q, pat_high_q;
  logic [15:0]                     wild_q;
  logic [wbpm_pkg::LenCfgW-1:0]    len_q;
  logic                            case_ins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      wild_q     <= '0;
      len_q      <= wbpm_pkg::LenCfgW'(1);
      case_ins_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wbpm_pkg::CfgPatLow:   pat_low_q  <= cfg_data_i;
        wbpm_pkg::CfgPatHigh:  pat_high_q <= cfg_data_i;
        wbpm_pkg::CfgWildMask: wild_q     <= cfg_data_i[15:0];
        wbpm_pkg::CfgPatLen:   len_q      <= cfg_data_i[wbpm_pkg::LenCfgW-1:0];
        wbpm_pkg::CfgCaseIns:  case_ins_q <= cfg_data_i[0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // length above the window depth acts as the full window
  logic [LenW-1:0] len_eff;
  always_comb begin
    if (32'(len_q) > PATTERN_MAX) begin
      len_eff = LenW'(PATTERN_MAX);
    end else begin
      len_eff = LenW'(len_q);
    end
  end

  logic [127:0] pat_all;
  assign pat_all = {pat_high_q, pat_low_q};

  // handshake and shared cell control
  logic                 out_valid_q;
  wbpm_pkg::out_beat_t  out_data_q;
  logic                 accept;
  wbpm_pkg::cell_ctrl_t ctrl;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign ctrl.shift = accept;
  assign ctrl.clear = in_i.data.last_byte;
  assign ctrl.fold  = case_ins_q;

  // cell row: slot k holds the byte seen k beats back, slot 0 newest
  logic [PATTERN_MAX-1:0] cell_match;
  logic [7:0]             cell_byte [PATTERN_MAX];

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [wbpm_pkg::PosW-1:0] pos;
    wbpm_pkg::cell_pat_t       pat;
    logic [7:0]                byte_in;

    // slot k lines up with pattern position len-1-k
    assign pos = wbpm_pkg::PosW'(len_eff) - wbpm_pkg::PosW'(k) - wbpm_pkg::PosW'(1);

    always_comb begin
      pat.active = (wbpm_pkg::PosW'(k) < wbpm_pkg::PosW'(len_eff));
      if (pos < wbpm_pkg::PosW'(wbpm_pkg::CfgPositions)) begin
        pat.pat_byte = pat_all[{pos[3:0], 3'b000} +: 8];
        pat.wild     = wild_q[pos[3:0]];
      end else begin
        // positions past the configured sixteen are literal zero
        pat.pat_byte = 8'h00;
        pat.wild     = 1'b0;
      end
    end

    if (k == 0) begin : g_head
      assign byte_in = in_i.data.data_byte;
    end else begin : g_body
      assign byte_in = cell_byte[k-1];
    end

    wbpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .pat_i   (pat),
      .byte_i  (byte_in),
      .byte_o  (cell_byte[k]),
      .match_o (cell_match[k])
    );
  end

  // byte count within the file, saturating
  logic [OFFSET_BITS-1:0] seen_q, seen_now;
  logic                   any_q;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start_off;
  logic [wbpm_pkg::OutOffW-1:0] off_out;

  assign seen_now = seen_q + OFFSET_BITS'(seen_q != '1);

  // a hit needs a full window of the current file
  assign hit = (len_eff != '0) && (seen_now >= OFFSET_BITS'(len_eff)) && (&cell_match);

  assign start_off = seen_now - OFFSET_BITS'(len_eff);

  if (OFFSET_BITS >= wbpm_pkg::OutOffW) begin : g_off_trunc
    assign off_out = start_off[wbpm_pkg::OutOffW-1:0];
  end else begin : g_off_ext
    assign off_out = wbpm_pkg::OutOffW'(start_off);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      any_q  <= 1'b0;
    end else if (accept) begin
      if (in_i.data.last_byte) begin
        seen_q <= '0;
        any_q  <= 1'b0;
      end else begin
        seen_q <= seen_now;
        any_q  <= any_q || hit;
      end
    end
  end

  // output register parts the two sides
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q.match_hit      <= hit;
      out_data_q.match_offset   <= hit ? off_out : '0;
      out_data_q.first_hit      <= hit && !any_q;
      out_data_q.file_end       <= in_i.data.last_byte;
      out_data_q.file_had_match <= hit || any_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
